// ===== sv/uyvy_letterbox_fit_addressing_defines.svh =====
// assertion macros shared by the letterbox addressing rtl
`ifndef UYVY_LETTERBOX_FIT_ADDRESSING_DEFINES_SVH
`define UYVY_LETTERBOX_FIT_ADDRESSING_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ULFA_ASSERT_IMPLY(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication, disabled during reset
`define ULFA_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ===== sv/ulfa_pkg.sv =====
// constants, types and the divider step shared by the letterbox addressing rtl
package ulfa_pkg;

   localparam int OUT_WIDTH_PIXELS = 640;
   localparam int OUT_HEIGHT_LINES = 480;

   // coordinate and size width, covers the 13-bit source registers
   localparam int DIM_W    = 13;
   localparam int NUM_W    = 2 * DIM_W;
   localparam int STEPS    = DIM_W;
   localparam int STRIDE_W = 16;
   localparam int OFS_W    = 28;
   localparam int LINE_W   = 9;
   localparam int PAIR_W   = 9;
   localparam int PX_W     = PAIR_W + 1;
   localparam int ADDR_W   = 4;

   localparam logic [DIM_W-1:0] FRAME_W = DIM_W'(OUT_WIDTH_PIXELS);
   localparam logic [DIM_W-1:0] FRAME_H = DIM_W'(OUT_HEIGHT_LINES);

   localparam logic [1:0] REG_SOURCE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_SOURCE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_LINE_STRIDE    = 2'd2;
   localparam logic [1:0] REG_STACKED_FIELDS = 2'd3;

   typedef struct packed {
      logic valid;
      logic pad;
   } ctl_type;

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [DIM_W-1:0] dvs);
      logic [DIM_W:0] t;
      logic [DIM_W:0] d;
      t = {rem, bit_in};
      d = t - {1'b0, dvs};
      if (t >= {1'b0, dvs}) begin
         return {1'b1, d[DIM_W-1:0]};
      end
      return {1'b0, t[DIM_W-1:0]};
   endfunction

endpackage

// ===== sv/ulfa_div_pipe.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
module ulfa_div_pipe
   import ulfa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  ctl_type          ctl_i,
   input  logic [NUM_W-1:0] num_x,
   input  logic [NUM_W-1:0] num_y,
   input  logic [DIM_W-1:0] dvs_x,
   input  logic [DIM_W-1:0] dvs_y,
   output ctl_type          ctl_o,
   output logic [DIM_W-1:0] q_x,
   output logic [DIM_W-1:0] q_y
);

   ctl_type          ctl_ff   [STEPS];
   logic [DIM_W-1:0] rem_x_ff [STEPS];
   logic [DIM_W-1:0] rem_y_ff [STEPS];
   logic [DIM_W-1:0] lo_x_ff  [STEPS];
   logic [DIM_W-1:0] lo_y_ff  [STEPS];
   logic [DIM_W-1:0] q_x_ff   [STEPS];
   logic [DIM_W-1:0] q_y_ff   [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      ctl_type          ci;
      logic [DIM_W-1:0] rx, ry, lx, ly, qx, qy;
      logic [DIM_W:0]   rs_x, rs_y;

      if (k == 0) begin : g_first
         // quotient is known to fit DIM_W bits, so the top half starts as remainder
         assign ci = ctl_i;
         assign rx = num_x[NUM_W-1:DIM_W];
         assign ry = num_y[NUM_W-1:DIM_W];
         assign lx = num_x[DIM_W-1:0];
         assign ly = num_y[DIM_W-1:0];
         assign qx = '0;
         assign qy = '0;
      end else begin : g_next
         assign ci = ctl_ff[k-1];
         assign rx = rem_x_ff[k-1];
         assign ry = rem_y_ff[k-1];
         assign lx = lo_x_ff[k-1];
         assign ly = lo_y_ff[k-1];
         assign qx = q_x_ff[k-1];
         assign qy = q_y_ff[k-1];
      end

      assign rs_x = div_step(rx, lx[DIM_W-1], dvs_x);
      assign rs_y = div_step(ry, ly[DIM_W-1], dvs_y);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[k].valid <= ci.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff[k].pad <= ci.pad;
            rem_x_ff[k]   <= rs_x[DIM_W-1:0];
            rem_y_ff[k]   <= rs_y[DIM_W-1:0];
            lo_x_ff[k]    <= {lx[DIM_W-2:0], 1'b0};
            lo_y_ff[k]    <= {ly[DIM_W-2:0], 1'b0};
            q_x_ff[k]     <= {qx[DIM_W-2:0], rs_x[DIM_W]};
            q_y_ff[k]     <= {qy[DIM_W-2:0], rs_y[DIM_W]};
         end
      end
   end

   assign ctl_o = ctl_ff[STEPS-1];
   assign q_x   = q_x_ff[STEPS-1];
   assign q_y   = q_y_ff[STEPS-1];

endmodule

// ===== sv/uyvy_letterbox_fit_addressing.sv =====
// Letterbox addressing for a fixed UYVY output frame: each item is an output line and
// pixel-pair index, each result a padding flag and the nearest-neighbor source byte
// offset. One item is accepted per cycle and its result is presented through 18 register
// stages: input capture, region test, scale multiply, the 13-stage quotient pipeline that
// scales x and y, clamping and the offset multiply-add. A stalled result holds the whole
// pipeline. After reset and after every register write the fit (size and offsets) is
// recomputed by a sequential divider (the division is skipped when the source is stacked
// or a size is zero), during which req_tready stays low.
`include "uyvy_letterbox_fit_addressing_defines.svh"

module uyvy_letterbox_fit_addressing
   import ulfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // out_line [8:0], out_pair [17:9], zero [23:18]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // source_offset [27:0], zero [31:28]
   output logic              rsp_tuser,   // is_padding
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [2:0] {
      FIT_MUL, FIT_DEC, FIT_DIV, FIT_SET, FIT_OFS, FIT_IDLE
   } fit_state_type;

   logic [DIM_W-1:0]    sw_ff, sh_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic                stacked_ff;
   logic                wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff      <= FRAME_W;
         sh_ff      <= FRAME_H;
         stride_ff  <= STRIDE_W'(1280);
         stacked_ff <= 1'b0;
      end else if (wr) begin
         case (csr_paddr[3:2])
            REG_SOURCE_WIDTH:   sw_ff      <= csr_pwdata[DIM_W-1:0];
            REG_SOURCE_HEIGHT:  sh_ff      <= csr_pwdata[DIM_W-1:0];
            REG_LINE_STRIDE:    stride_ff  <= csr_pwdata[STRIDE_W-1:0];
            REG_STACKED_FIELDS: stacked_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SOURCE_WIDTH:   csr_prdata = 32'(sw_ff);
         REG_SOURCE_HEIGHT:  csr_prdata = 32'(sh_ff);
         REG_LINE_STRIDE:    csr_prdata = 32'(stride_ff);
         REG_STACKED_FIELDS: csr_prdata = 32'(stacked_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // fit computation
   fit_state_type    fit_state_ff;
   logic [NUM_W-1:0] pa_ff, pb_ff;
   logic [DIM_W-1:0] frem_ff, flo_ff, fq_ff, fdvs_ff;
   logic [3:0]       fcnt_ff;
   logic             ftgt_w_ff;
   logic [DIM_W-1:0] ow_ff, oh_ff, ox_ff, oy_ff, lim_ff;
   logic             fit_ok_ff;
   logic [DIM_W:0]   fstep;
   logic [DIM_W-1:0] fw_diff;

   assign fstep   = div_step(frem_ff, flo_ff[DIM_W-1], fdvs_ff);
   assign fw_diff = FRAME_W - ow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_state_ff <= FIT_MUL;
         fit_ok_ff    <= 1'b0;
      end else if (wr) begin
         fit_state_ff <= FIT_MUL;
         fit_ok_ff    <= 1'b0;
      end else begin
         case (fit_state_ff)
            FIT_MUL: begin
               pa_ff        <= NUM_W'(sw_ff) * NUM_W'(FRAME_H);
               pb_ff        <= NUM_W'(sh_ff) * NUM_W'(FRAME_W);
               fit_state_ff <= FIT_DEC;
            end
            FIT_DEC: begin
               fcnt_ff <= '0;
               if (sw_ff == '0 || sh_ff == '0) begin
                  ow_ff        <= '0;
                  oh_ff        <= '0;
                  fit_state_ff <= FIT_OFS;
               end else if (stacked_ff) begin
                  ow_ff        <= FRAME_W;
                  oh_ff        <= FRAME_H;
                  fit_state_ff <= FIT_OFS;
               end else if (pa_ff > pb_ff) begin
                  ftgt_w_ff    <= 1'b0;
                  frem_ff      <= pb_ff[NUM_W-1:DIM_W];
                  flo_ff       <= pb_ff[DIM_W-1:0];
                  fdvs_ff      <= sw_ff;
                  fit_state_ff <= FIT_DIV;
               end else begin
                  ftgt_w_ff    <= 1'b1;
                  frem_ff      <= pa_ff[NUM_W-1:DIM_W];
                  flo_ff       <= pa_ff[DIM_W-1:0];
                  fdvs_ff      <= sh_ff;
                  fit_state_ff <= FIT_DIV;
               end
            end
            FIT_DIV: begin
               frem_ff <= fstep[DIM_W-1:0];
               flo_ff  <= {flo_ff[DIM_W-2:0], 1'b0};
               fq_ff   <= {fq_ff[DIM_W-2:0], fstep[DIM_W]};
               fcnt_ff <= fcnt_ff + 4'd1;
               if (fcnt_ff == 4'(STEPS - 1)) begin
                  fit_state_ff <= FIT_SET;
               end
            end
            FIT_SET: begin
               if (ftgt_w_ff) begin
                  ow_ff <= {fq_ff[DIM_W-1:1], 1'b0};
                  oh_ff <= FRAME_H;
               end else begin
                  ow_ff <= FRAME_W;
                  oh_ff <= {fq_ff[DIM_W-1:1], 1'b0};
               end
               fit_state_ff <= FIT_OFS;
            end
            FIT_OFS: begin
               ox_ff        <= {1'b0, fw_diff[DIM_W-1:2], 1'b0};
               oy_ff        <= (FRAME_H - oh_ff) >> 1;
               lim_ff       <= (sw_ff >= DIM_W'(2)) ? sw_ff - DIM_W'(2) : '0;
               fit_ok_ff    <= (ow_ff != '0) && (oh_ff != '0);
               fit_state_ff <= FIT_IDLE;
            end
            FIT_IDLE: ;
            default: fit_state_ff <= FIT_MUL;
         endcase
      end
   end

   // item pipeline, one global advance enable
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && (fit_state_ff == FIT_IDLE);

   logic              v1_ff;
   logic [LINE_W-1:0] line1_ff;
   logic [PX_W-1:0]   px1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         line1_ff <= req_tdata[LINE_W-1:0];
         px1_ff   <= {req_tdata[LINE_W+PAIR_W-1:LINE_W], 1'b0};
      end
   end

   // region test and offsets into the fitted window
   ctl_type          ctl2_ff;
   logic [DIM_W-1:0] dx2_ff, dy2_ff;
   logic [DIM_W:0]   ln_e, px_e, ox_e, oy_e;
   logic             in_region;

   assign ln_e = (DIM_W+1)'(line1_ff);
   assign px_e = (DIM_W+1)'(px1_ff);
   assign ox_e = {1'b0, ox_ff};
   assign oy_e = {1'b0, oy_ff};
   assign in_region = fit_ok_ff && (ln_e >= oy_e) && (ln_e < oy_e + {1'b0, oh_ff})
                      && (px_e >= ox_e) && (px_e < ox_e + {1'b0, ow_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
      end else if (en) begin
         ctl2_ff.valid <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl2_ff.pad <= !in_region;
         dx2_ff      <= px_e[DIM_W-1:0] - ox_ff;
         dy2_ff      <= ln_e[DIM_W-1:0] - oy_ff;
      end
   end

   // scale numerators
   ctl_type          ctl3_ff;
   logic [NUM_W-1:0] nx3_ff, ny3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
      end else if (en) begin
         ctl3_ff.valid <= ctl2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl3_ff.pad <= ctl2_ff.pad;
         nx3_ff      <= NUM_W'(dx2_ff) * NUM_W'(sw_ff);
         ny3_ff      <= NUM_W'(dy2_ff) * NUM_W'(sh_ff);
      end
   end

   ctl_type          ctl4;
   logic [DIM_W-1:0] qx4, qy4;

   ulfa_div_pipe u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .ctl_i (ctl3_ff),
      .num_x (nx3_ff),
      .num_y (ny3_ff),
      .dvs_x (ow_ff),
      .dvs_y (oh_ff),
      .ctl_o (ctl4),
      .q_x   (qx4),
      .q_y   (qy4)
   );

   // rounding, clamping and field mapping
   ctl_type          ctl5_ff;
   logic [DIM_W-1:0] sx5_ff, sy5_ff;
   logic [DIM_W-1:0] sx_even, sh_half;
   logic [DIM_W:0]   sy_map;

   assign sx_even = {qx4[DIM_W-1:1], 1'b0};
   assign sh_half = sh_ff >> 1;
   assign sy_map  = stacked_ff ? (DIM_W+1)'(qy4 >> 1) + (qy4[0] ? {1'b0, sh_half} : '0)
                               : {1'b0, qy4};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff.valid <= 1'b0;
      end else if (en) begin
         ctl5_ff.valid <= ctl4.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl5_ff.pad <= ctl4.pad;
         sx5_ff      <= (sx_even > lim_ff) ? lim_ff : sx_even;
         sy5_ff      <= (sy_map >= {1'b0, sh_ff}) ? sh_ff - DIM_W'(1) : sy_map[DIM_W-1:0];
      end
   end

   // byte offset
   logic              v6_ff, pad6_ff;
   logic [OFS_W-1:0]  ofs6_ff;
   logic [OFS_W-1:0]  ofs_sum;

   assign ofs_sum = OFS_W'(OFS_W'(sy5_ff) * OFS_W'(stride_ff)) + OFS_W'({sx5_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= ctl5_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pad6_ff <= ctl5_ff.pad;
         ofs6_ff <= ctl5_ff.pad ? '0 : ofs_sum;
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tuser  = pad6_ff;
   assign rsp_tdata  = {{(32-OFS_W){1'b0}}, ofs6_ff};

   `ULFA_ASSERT_IMPLY(a_accept_fit_ready, clock, reset, req_tvalid && req_tready,
      fit_state_ff == FIT_IDLE, "item accepted while fit is being recomputed")
   `ULFA_ASSERT_NEXT(a_write_blocks, clock, reset, wr, !req_tready,
      "input ready right after a register write")
   `ULFA_ASSERT_IMPLY(a_pad_zero, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata == 32'd0, "padding result with nonzero offset")
   `ULFA_ASSERT_IMPLY(a_fit_bounds, clock, reset, fit_ok_ff,
      (ow_ff <= FRAME_W) && (oh_ff <= FRAME_H), "fitted size exceeds frame")

endmodule
